>>> src/sha512_hash_engine_assert.svh
// Assertion macros shared by the checker of the SHA-512 hash engine.
// No dependencies.
`ifndef SHA512_HASH_ENGINE_ASSERT_SVH
`define SHA512_HASH_ENGINE_ASSERT_SVH
// Antecedent implies consequent in the same cycle.
`define SHA_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define SHA_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> src/sha_pkg.sv
// Package of the SHA-512 hash engine: word types, round constants, helpers.
// No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        final_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_word_t;

  // One schedule word for the back end; last marks the end of a message.
  typedef struct packed {
    logic [63:0] data;
    logic        last;
  } blk_word_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0][63:0] InitHash = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f,
    64'h510e527fade682d1, 64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908};

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    case (t)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

>>> src/sha_front.sv
// Front end: counts length, pads the message and emits schedule words.
// Depends on sha_pkg.
module sha_front import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      blk_valid_o,
  input  logic      blk_stall_i,
  output blk_word_t blk_word_o
);

  typedef enum logic [1:0] {FrIdle, FrMark, FrZero, FrLen} fr_state_e;

  fr_state_e   state_q;
  logic [3:0]  pos_q;
  logic [63:0] bits_q;
  logic [3:0]  nb;
  logic [63:0] keep;
  logic [63:0] padded;
  logic        adv;

  assign nb = (in_word_i.valid_bytes > 4'd8) ? 4'd8 : in_word_i.valid_bytes;
  assign keep = (nb == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
  assign padded = (in_word_i.message_word & keep) | (64'h80 << (7'd56 - {nb, 3'b000}));

  assign in_stall_o = (state_q != FrIdle) || blk_stall_i;
  assign adv = blk_valid_o && !blk_stall_i;

  always_comb begin
    blk_valid_o = 1'b1;
    blk_word_o = '{data: 64'd0, last: 1'b0};
    case (state_q)
      FrIdle: begin
        blk_valid_o = in_valid_i;
        if (!in_word_i.final_word || nb == 4'd8) begin
          blk_word_o.data = in_word_i.message_word;
        end else begin
          blk_word_o.data = padded;
        end
      end
      FrMark: blk_word_o.data = 64'h8000_0000_0000_0000;
      FrZero: blk_word_o.data = 64'd0;
      FrLen: begin
        blk_word_o.data = bits_q;
        blk_word_o.last = 1'b1;
      end
      default: blk_valid_o = 1'b0;
    endcase
  end

  // The upper length word is always a zero at slot 14, so every padding run
  // passes through FrZero before the length goes out at slot 15.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      pos_q <= '0;
      bits_q <= '0;
    end else if (adv) begin
      pos_q <= pos_q + 4'd1;
      case (state_q)
        FrIdle: begin
          if (!in_word_i.final_word) begin
            bits_q <= bits_q + 64'd64;
          end else begin
            bits_q <= bits_q + {57'd0, nb, 3'b000};
            if (nb == 4'd8) state_q <= FrMark;
            else state_q <= FrZero;
          end
        end
        FrMark: state_q <= FrZero;
        FrZero: if (pos_q == 4'd14) state_q <= FrLen;
        FrLen: begin
          state_q <= FrIdle;
          bits_q <= '0;
        end
        default: state_q <= FrIdle;
      endcase
    end
  end

endmodule

>>> src/sha_queue.sv
// Short queue between the front end and the compression back end.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_stall_o,
  input  blk_word_t wr_word_i,
  output logic      rd_valid_o,
  input  logic      rd_stall_i,
  output blk_word_t rd_word_o
);

  localparam int unsigned Aw = $clog2(QueueDepth);

  blk_word_t            mem_q [QueueDepth];
  logic [Aw-1:0]        wp_q, rp_q;
  logic [Aw:0]          cnt_q;
  logic                 wr, rd;

  assign wr_stall_o = (cnt_q == (Aw+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_word_o = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + Aw'(1);
      if (rd) rp_q <= rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

endmodule

>>> src/sha_back.sv
// Back end: 16-word ring, 80 rounds one per cycle, digest output register.
// Depends on sha_pkg.
module sha_back import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      blk_valid_i,
  output logic      blk_stall_o,
  input  blk_word_t blk_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  typedef enum logic [1:0] {BkLoad, BkRound, BkAdd, BkEmit} bk_state_e;

  bk_state_e        state_q;
  logic [15:0][63:0] w_q;
  logic [7:0][63:0]  h_q;
  logic [7:0][63:0]  v_q;
  logic [3:0]        pos_q;
  logic [6:0]        rnd_q;
  logic              last_q;
  logic [2:0]        num_q;
  logic              ovalid_q;
  logic [63:0]       wt, t1, t2, s0, s1;
  logic [63:0]       ww2, ww15;

  assign blk_stall_o = (state_q != BkLoad);
  assign ww2 = w_q[14];
  assign ww15 = w_q[1];
  assign s0 = rotr(ww15, 1) ^ rotr(ww15, 8) ^ (ww15 >> 7);
  assign s1 = rotr(ww2, 19) ^ rotr(ww2, 61) ^ (ww2 >> 6);
  // The ring is kept as a shift line: w_q[0] is the word of the current round.
  assign wt = w_q[0];
  assign t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wt;
  assign t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign out_valid_o = ovalid_q;
  assign out_word_o = '{digest_word: h_q[num_q], word_number: num_q,
                        last_word: (num_q == 3'd7)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkLoad;
      h_q <= InitHash;
      pos_q <= '0;
      rnd_q <= '0;
      last_q <= 1'b0;
      num_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      case (state_q)
        BkLoad: if (blk_valid_i) begin
          w_q <= {blk_word_i.data, w_q[15:1]};
          pos_q <= pos_q + 4'd1;
          if (pos_q == 4'd15) begin
            last_q <= blk_word_i.last;
            v_q <= h_q;
            rnd_q <= '0;
            state_q <= BkRound;
          end
        end
        BkRound: begin
          v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
          w_q <= {s1 + w_q[9] + s0 + w_q[0], w_q[15:1]};
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= BkAdd;
        end
        BkAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (last_q) begin
            state_q <= BkEmit;
            ovalid_q <= 1'b1;
            num_q <= '0;
          end else begin
            state_q <= BkLoad;
          end
        end
        BkEmit: if (!out_stall_i) begin
          num_q <= num_q + 3'd1;
          if (num_q == 3'd7) begin
            ovalid_q <= 1'b0;
            h_q <= InitHash;
            state_q <= BkLoad;
          end
        end
        default: state_q <= BkLoad;
      endcase
    end
  end

endmodule

>>> src/sha512_hash_engine.sv
// Top level of the SHA-512 hash engine: front end, queue and back end.
// Depends on sha_pkg, sha_front, sha_queue and sha_back.
//
//   channel | direction | handshake               | word type
//   in      | input     | in_valid_i/in_stall_o   | in_word_t
//   out     | output    | out_valid_o/out_stall_i | out_word_t
//
// Each 16-word block is loaded, run through 80 rounds in the single round unit
// and added into the hash; the back end takes no word while a block is in work.
// A final word adds up to 18 padding words and then eight digest words.
// Reset clears all control state and restores the initial hash at once.
// The front end stalls while it inserts padding or while the queue is full.
module sha512_hash_engine import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic      f_valid, f_stall, q_valid, q_stall;
  blk_word_t f_word, q_word;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .blk_valid_o(f_valid), .blk_stall_i(f_stall), .blk_word_o(f_word)
  );

  sha_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_word_i(f_word),
    .rd_valid_o(q_valid), .rd_stall_i(q_stall), .rd_word_o(q_word)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .blk_valid_i(q_valid), .blk_stall_o(q_stall), .blk_word_i(q_word),
    .out_valid_o, .out_stall_i, .out_word_o
  );

endmodule

>>> src/sha_checker.sv
// Port checker of the SHA-512 hash engine, bound to the top level.
// Depends on sha_pkg and sha512_hash_engine_assert.svh.
`include "sha512_hash_engine_assert.svh"
module sha_checker import sha_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);
  `SHA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_word_o))
  `SHA_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid_o,
    out_word_o.last_word == (out_word_o.word_number == 3'd7))
  `SHA_ASSERT_NEXT(a_seq, clk_i, rst_ni,
    out_valid_o && !out_stall_i && !out_word_o.last_word,
    out_valid_o && out_word_o.word_number == $past(out_word_o.word_number) + 3'd1)
endmodule

bind sha512_hash_engine sha_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_word_o
);
